// File: src/tmo_pkg.sv
// Shared types, constants, microcode table and helper functions for the 3x-1 checker.
package tmo_pkg;

    localparam int ITER_W = 128;
    localparam int PC_W   = 2;

    localparam logic [63:0] WIDE_LIMIT     = 64'd6000000000000000000;
    localparam logic [63:0] KNOWN_CEILING  = 64'd136;
    localparam logic [15:0] STEP_CAP_RESET = 16'd4000;

    typedef logic [ITER_W-1:0] t_iter;
    typedef logic [PC_W-1:0]   t_pc;

    typedef enum logic [2:0] {
        OUT_DROPPED   = 3'd0,
        OUT_KNOWN_HIT = 3'd1,
        OUT_RETURNED  = 3'd2,
        OUT_NEW_CYCLE = 3'd3,
        OUT_STEP_CAP  = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAP,
        OP_TEST,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_RUNNING,
        CND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // one-cycle datapath strobes decoded from the current control word
    typedef struct packed {
        logic load;
        logic map;
        logic test;
        logic emit;
    } t_ctl;

    typedef struct packed {
        logic running;
    } t_stat;

    typedef struct packed {
        t_outcome    outcome;
        logic [16:0] steps;
        logic        wide;
        logic [16:0] most;
        logic [63:0] peak_upper;
        logic [63:0] peak_lower;
        logic [63:0] failures;
        logic [63:0] cycle_total;
        logic [63:0] wide_total;
    } t_result;

    localparam t_pc PC_WAIT = 2'd0;
    localparam t_pc PC_MAP  = 2'd1;
    localparam t_pc PC_TEST = 2'd2;
    localparam t_pc PC_EMIT = 2'd3;

    // Control store: jump to target when the condition holds, else fall through.
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            PC_WAIT: w = '{op: OP_LOAD, cond: CND_NO_INPUT, target: PC_WAIT};
            PC_MAP:  w = '{op: OP_MAP,  cond: CND_ALWAYS,   target: PC_TEST};
            PC_TEST: w = '{op: OP_TEST, cond: CND_RUNNING,  target: PC_MAP};
            PC_EMIT: w = '{op: OP_EMIT, cond: CND_OUT_BUSY, target: PC_EMIT};
            default: w = '{op: OP_NONE, cond: CND_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

    // members of the three known cycles, all at or below 136
    function automatic logic known_member(logic [7:0] v);
        logic k;
        case (v)
            8'd1, 8'd5, 8'd7, 8'd10, 8'd17, 8'd25, 8'd34, 8'd37,
            8'd41, 8'd55, 8'd61, 8'd68, 8'd82, 8'd91, 8'd136: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

endpackage

// File: src/three_x_minus_one_trajectory_check.sv
// Top level of the 3x-1 trajectory checker: sequencer, datapath and output register.
//
// Accepts one odd start value per beat and runs the shortcut map g(v) = v/2 (even),
// (3v-1)/2 (odd) on a 128-bit iterate that wraps, until the iterate drops below the
// start, returns to it, lands on a known cycle member, or runs past i_cfg_wdata's
// step cap (reset 4000). One result beat follows each start, carrying the outcome,
// the step count, a wide-final flag, the running maximum step count, the running
// peak iterate and running totals of failures, new cycles and wide finals. A small
// microcode program sequences the work: each map step is a map state, which advances
// the iterate through the adder, followed by a test state, which compares it against
// the peak and the stop rules, so a start passes through accept, one map/test pair
// per step, and emit. The next start is taken as soon as the previous result has
// been moved into the output register, even while that result is still stalled.
// Write the step cap only while no start is in flight.
module three_x_minus_one_trajectory_check import tmo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_start_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_outcome,
    output logic [16:0] o_steps_taken,
    output logic        o_final_is_wide,
    output logic [16:0] o_most_steps_so_far,
    output logic [63:0] o_peak_upper,
    output logic [63:0] o_peak_lower,
    output logic [63:0] o_failures_so_far,
    output logic [63:0] o_new_cycles_so_far,
    output logic [63:0] o_wide_so_far
);

    t_ctl    w_ctl;
    t_stat   w_stat;
    t_result w_result;
    logic    w_in_ready;
    logic    w_out_busy;

    logic    r_out_valid;
    t_result r_out;

    // output register holds a stalled result; emit waits only while it is occupied
    assign w_out_busy = r_out_valid && i_out_stall;
    assign o_in_stall = !w_in_ready;

    tmo_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (w_out_busy),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl),
        .o_in_ready (w_in_ready)
    );

    tmo_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_start_value (i_start_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_stat        (w_stat),
        .o_result      (w_result)
    );

    // advance valid on emit, drop it once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_outcome           = r_out.outcome;
    assign o_steps_taken       = r_out.steps;
    assign o_final_is_wide     = r_out.wide;
    assign o_most_steps_so_far = r_out.most;
    assign o_peak_upper        = r_out.peak_upper;
    assign o_peak_lower        = r_out.peak_lower;
    assign o_failures_so_far   = r_out.failures;
    assign o_new_cycles_so_far = r_out.cycle_total;
    assign o_wide_so_far       = r_out.wide_total;

`ifndef SYNTHESIS
    a_steps_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_steps_taken != 17'd0) && (o_most_steps_so_far >= o_steps_taken)))
        else $error("result step counts inconsistent");
`endif

endmodule

// File: src/tmo_sequencer.sv
// Microcode sequencer: program counter, control store lookup and conditional jumps.
module tmo_sequencer import tmo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_busy,
    input  t_stat i_stat,
    output t_ctl  o_ctl,
    output logic  o_in_ready
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_jump;

    assign w_uw = ucode(r_pc);

    always_comb begin
        case (w_uw.cond)
            CND_ALWAYS:   w_jump = 1'b1;
            CND_NO_INPUT: w_jump = !i_in_valid;
            CND_RUNNING:  w_jump = i_stat.running;
            CND_OUT_BUSY: w_jump = i_out_busy;
            default:      w_jump = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = w_jump ? w_uw.target : r_pc + t_pc'(1);
    end

    always_comb begin
        o_ctl.load = (w_uw.op == OP_LOAD) && i_in_valid;
        o_ctl.map  = (w_uw.op == OP_MAP);
        o_ctl.test = (w_uw.op == OP_TEST);
        o_ctl.emit = (w_uw.op == OP_EMIT) && !i_out_busy;
    end

    assign o_in_ready = (w_uw.op == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

`ifndef SYNTHESIS
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.load, o_ctl.map, o_ctl.test, o_ctl.emit}))
        else $error("more than one datapath strobe active");
    a_load_to_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> o_ctl.map)
        else $error("accepted start not followed by a map step");
`endif

endmodule

// File: src/tmo_datapath.sv
// Datapath: iterate, step count, peak, stop tests, totals and the step cap register.
module tmo_datapath import tmo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  logic [63:0] i_start_value,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output t_stat       o_stat,
    output t_result     o_result
);

    t_iter       r_iter;
    t_iter       r_peak;
    logic [63:0] r_start;
    logic [16:0] r_count;
    logic [16:0] r_max;
    logic [63:0] r_fail_total;
    logic [63:0] r_new_total;
    logic [63:0] r_wide_total;
    logic [15:0] r_step_cap;
    t_outcome    r_outcome;

    t_iter       w_triple;
    t_iter       n_iter;
    logic [63:0] w_lo;
    logic        w_upper_zero;
    logic        w_drop;
    logic        w_ret;
    logic        w_hit;
    logic        w_cap;
    logic        w_start_known;
    t_outcome    n_outcome;
    logic        w_wide;
    logic [16:0] n_max;
    logic [127:0] w_peak_ext;

    // one map step: triple mod 2^ITER_W when odd, then halve
    assign w_triple = r_iter + (r_iter << 1);
    assign n_iter   = r_iter[0] ? (w_triple >> 1) : (r_iter >> 1);

    assign w_lo          = r_iter[63:0];
    assign w_upper_zero  = ((r_iter >> 64) == '0);
    assign w_start_known = (r_start <= KNOWN_CEILING) && known_member(r_start[7:0]);

    assign w_drop = w_upper_zero && (w_lo < r_start);
    assign w_ret  = w_upper_zero && (w_lo == r_start);
    assign w_hit  = w_upper_zero && (w_lo <= KNOWN_CEILING) && known_member(w_lo[7:0]);
    assign w_cap  = r_count > {1'b0, r_step_cap};

    always_comb begin
        if (w_drop) begin
            n_outcome = OUT_DROPPED;
        end else if (w_ret) begin
            n_outcome = w_start_known ? OUT_RETURNED : OUT_NEW_CYCLE;
        end else if (w_hit) begin
            n_outcome = OUT_KNOWN_HIT;
        end else begin
            n_outcome = OUT_STEP_CAP;
        end
    end

    assign o_stat.running = !(w_drop || w_ret || w_hit || w_cap);

    assign w_wide     = !w_upper_zero || (w_lo > WIDE_LIMIT);
    assign n_max      = (r_count > r_max) ? r_count : r_max;
    assign w_peak_ext = 128'(r_peak);

    always_comb begin
        o_result.outcome     = r_outcome;
        o_result.steps       = r_count;
        o_result.wide        = w_wide;
        o_result.most        = n_max;
        o_result.peak_upper  = w_peak_ext[127:64];
        o_result.peak_lower  = w_peak_ext[63:0];
        o_result.failures    = r_fail_total + 64'(r_outcome == OUT_STEP_CAP);
        o_result.cycle_total = r_new_total + 64'(r_outcome == OUT_NEW_CYCLE);
        o_result.wide_total  = r_wide_total + 64'(w_wide);
    end

    // payload: start, iterate, count, outcome
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_start <= i_start_value;
            r_iter  <= ITER_W'(i_start_value);
            r_count <= '0;
        end else if (i_ctl.map) begin
            r_iter  <= n_iter;
            r_count <= r_count + 17'd1;
        end
        if (i_ctl.test) begin
            r_outcome <= n_outcome;
        end
    end

    // running state since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak       <= '0;
            r_max        <= '0;
            r_fail_total <= '0;
            r_new_total  <= '0;
            r_wide_total <= '0;
            r_step_cap   <= STEP_CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_step_cap <= i_cfg_wdata;
            end
            if (i_ctl.test && (r_iter > r_peak)) begin
                r_peak <= r_iter;
            end
            if (i_ctl.emit) begin
                r_max        <= n_max;
                r_fail_total <= o_result.failures;
                r_new_total  <= o_result.cycle_total;
                r_wide_total <= o_result.wide_total;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.test |-> (r_count <= ({1'b0, r_step_cap} + 17'd1)))
        else $error("step count ran past the cap");
    a_peak_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_peak >= $past(r_peak)))
        else $error("running peak decreased");
`endif

endmodule
